/* rtl/lfu_cache_table_top_assert.svh */
// assertion macros used by the checker
`ifndef LFU_CACHE_TABLE_TOP_ASSERT_SVH
`define LFU_CACHE_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lfu_pkg.sv */
package lfu_pkg;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [15:0] COUNT_INIT = 16'd1;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [4:0]  CAP_RESET  = 5'd16;

	// one stored entry
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] data;
		logic [15:0] count;
		logic [31:0] stamp;
	} entry_t;

	// running scan result handed back to the sequencer
	typedef struct packed {
		logic        hit;
		logic [31:0] hit_data;
		logic [15:0] hit_count;
		logic [31:0] vic_key;
	} scan_res_t;

endpackage

/* rtl/lfu_ram.sv */
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lfu_scan.sv */
module lfu_scan import lfu_pkg::*; #(
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          eval,
	input  logic [AW-1:0] slot,
	input  entry_t        rec,
	input  logic [31:0]   key,
	input  logic [31:0]   tclk,
	output scan_res_t     res,
	output logic [AW-1:0] hit_slot,
	output logic [AW-1:0] vic_slot
);

	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	logic [31:0]   hit_data_q;
	logic [15:0]   hit_cnt_q;
	logic          have_q;
	logic [AW-1:0] vic_slot_q;
	logic [15:0]   vic_cnt_q;
	logic [31:0]   vic_age_q;
	logic [31:0]   vic_key_q;

	logic [31:0] age;
	logic        better;

	// age wraps modulo 2^32, larger is older
	assign age    = tclk - rec.stamp;
	assign better = !have_q || (rec.count < vic_cnt_q) ||
		((rec.count == vic_cnt_q) && (age > vic_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_slot_q <= '0;
			hit_data_q <= '0;
			hit_cnt_q  <= '0;
			have_q     <= 1'b0;
			vic_slot_q <= '0;
			vic_cnt_q  <= '0;
			vic_age_q  <= '0;
			vic_key_q  <= '0;
		end else if (clear) begin
			hit_q  <= 1'b0;
			have_q <= 1'b0;
		end else if (eval) begin
			if (rec.key == key) begin
				hit_q      <= 1'b1;
				hit_slot_q <= slot;
				hit_data_q <= rec.data;
				hit_cnt_q  <= rec.count;
			end
			if (better) begin
				have_q     <= 1'b1;
				vic_slot_q <= slot;
				vic_cnt_q  <= rec.count;
				vic_age_q  <= age;
				vic_key_q  <= rec.key;
			end
		end
	end

	assign res.hit       = hit_q;
	assign res.hit_data  = hit_data_q;
	assign res.hit_count = hit_cnt_q;
	assign res.vic_key   = vic_key_q;
	assign hit_slot      = hit_slot_q;
	assign vic_slot      = vic_slot_q;

endmodule

/* rtl/lfu_cache_table_top.sv */
// lfu cache table: key/value store with least-frequently-used replacement
// an accepted item steps through the scan, last and write states; the entry ram is read one slot per cycle
// while scanning, and the scan is skipped when the table is empty or disabled; no new item is taken
// until the result is loaded, so a stalled result also holds the input
// reset: table empty, touch clock zero, capacity 16, no result pending
module lfu_cache_table_top import lfu_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	// request items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] read_value,
	output logic               evicted,
	output logic signed [31:0] evicted_key
);

	// slot index width, fill count width, and a width wide enough to compare both
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (OW > 5) ? OW : 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE
	} state_t;

	state_t        state_q;
	logic [4:0]    cap_q;
	logic [OW-1:0] occ_q;
	logic [31:0]   tclk_q;
	logic          cmd_q;
	logic [31:0]   key_q;
	logic [31:0]   val_q;
	logic [AW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] addr_s1;

	logic          out_valid_q;
	logic          hit_q;
	logic [31:0]   read_value_q;
	logic          evicted_q;
	logic [31:0]   evicted_key_q;

	// ram and scan unit wiring
	entry_t        rd_rec;
	entry_t        wr_rec;
	logic          ram_we;
	logic [AW-1:0] wr_addr;
	scan_res_t     scan;
	logic [AW-1:0] hit_slot;
	logic [AW-1:0] vic_slot;

	logic              accept;
	logic              go;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  cap_eff;
	logic [CMP_W-1:0]  occ_ext;
	logic [OW-1:0]     occ_m1;
	logic              full;

	// decision of the write-back cycle
	logic          wr_en;
	logic          nx_hit;
	logic [31:0]   nx_rd;
	logic          nx_ev;
	logic [31:0]   nx_evk;
	logic          nx_grow;
	logic          nx_tick;
	logic [15:0]   cnt_inc;

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// writing capacity above the table size acts as the table size
	assign cap_ext = CMP_W'(cap_q);
	assign cap_eff = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
	assign occ_ext = CMP_W'(occ_q);
	assign full    = (occ_ext >= cap_eff);
	assign occ_m1  = occ_q - 1'b1;

	// the result may only be loaded once the previous one has left
	assign go = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);

	assign cnt_inc = (scan.hit_count == COUNT_MAX) ? COUNT_MAX : (scan.hit_count + 16'd1);

	// valid entries always fill slots 0 .. occupancy-1, an eviction reuses its slot
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_slot;
		wr_rec  = '{key: key_q, data: val_q, count: COUNT_INIT, stamp: tclk_q};
		nx_hit  = 1'b0;
		nx_rd   = MISS_VALUE;
		nx_ev   = 1'b0;
		nx_evk  = '0;
		nx_grow = 1'b0;
		nx_tick = 1'b0;
		if (cap_eff != '0) begin
			if (scan.hit) begin
				wr_en        = 1'b1;
				nx_hit       = 1'b1;
				nx_tick      = 1'b1;
				wr_rec.count = cnt_inc;
				if (cmd_q == CMD_GET) begin
					wr_rec.data = scan.hit_data;
					nx_rd       = scan.hit_data;
				end
			end else if (cmd_q == CMD_PUT) begin
				wr_en   = 1'b1;
				nx_tick = 1'b1;
				if (full) begin
					// least used, then least recently touched, then lowest slot
					wr_addr = vic_slot;
					nx_ev   = 1'b1;
					nx_evk  = scan.vic_key;
				end else begin
					wr_addr = occ_q[AW-1:0];
					nx_grow = 1'b1;
				end
			end
		end
	end

	assign ram_we = go && wr_en;

	lfu_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (wr_rec),
		.raddr (idx_q),
		.rdata (rd_rec)
	);

	// one entry per cycle goes through the compare unit, in the cycle after its ram read
	lfu_scan #(
		.AW (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.eval     (rd_vld_s1),
		.slot     (addr_s1),
		.rec      (rd_rec),
		.key      (key_q),
		.tclk     (tclk_q),
		.res      (scan),
		.hit_slot (hit_slot),
		.vic_slot (vic_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cap_q         <= CAP_RESET;
			occ_q         <= '0;
			tclk_q        <= '0;
			cmd_q         <= CMD_GET;
			key_q         <= '0;
			val_q         <= '0;
			idx_q         <= '0;
			rd_vld_s1     <= 1'b0;
			addr_s1       <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			read_value_q  <= '0;
			evicted_q     <= 1'b0;
			evicted_key_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// a taken result leaves unless the next one replaces it in the same cycle
			if (out_valid_q && !out_stall && !go) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			addr_s1   <= idx_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						key_q <= key;
						val_q <= value;
						idx_q <= '0;
						// nothing to look at when disabled or empty
						if ((cap_eff == '0) || (occ_q == '0)) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == occ_m1[AW-1:0]) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					// final entry is compared in this cycle
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (go) begin
						out_valid_q   <= 1'b1;
						hit_q         <= nx_hit;
						read_value_q  <= nx_rd;
						evicted_q     <= nx_ev;
						evicted_key_q <= nx_evk;
						if (nx_grow) begin
							occ_q <= occ_q + 1'b1;
						end
						if (nx_tick) begin
							tclk_q <= tclk_q + 32'd1;
						end
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

/* rtl/lfu_checker.sv */
`include "lfu_cache_table_top_assert.svh"

module lfu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [4:0]         cfg_wdata,
	input logic               in_valid,
	input logic               in_stall,
	input logic               command,
	input logic signed [31:0] key,
	input logic signed [31:0] value,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic signed [31:0] read_value,
	input logic               evicted,
	input logic signed [31:0] evicted_key
);

	// the request side closes after an accept, while the lookup runs
	`LFU_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not block input")

	// a stalled result stays valid and holds its read value and evicted key
	`LFU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_value) && $stable(evicted_key), "stalled result changed")

	// an eviction only happens on a put of an absent key
	`LFU_ASSERT_IMP(a_evict_is_miss, out_valid && evicted, !hit && (read_value == -32'sd1), "eviction reported with hit or read data")

	// no eviction means a zero evicted key
	`LFU_ASSERT_IMP(a_evkey_zero, out_valid && !evicted, evicted_key == 32'sd0, "evicted key set without eviction")

endmodule

bind lfu_cache_table_top lfu_checker u_lfu_checker (.*);

/* tb/sv/tb_lfu_cache_table_top.sv */
module tb_lfu_cache_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lfu_pkg::*;

	localparam int SLOTS = 16;
	// idle cycles left after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 24;

	// one request item as driven on the input side
	typedef struct packed {
		logic        command;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	// one result item as seen on the output side
	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic        evicted;
		logic [31:0] evicted_key;
	} reply_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	// block inputs, all known from time zero
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = CAP_RESET;
	logic        in_valid = 1'b0;
	logic        command = CMD_GET;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        out_stall = 1'b0;

	// block outputs
	logic               in_stall;
	logic               out_valid;
	logic               hit;
	logic signed [31:0] read_value;
	logic               evicted;
	logic signed [31:0] evicted_key;

	lfu_cache_table_top #(.CAPACITY(SLOTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

	// shared testbench state
	request_t    pending_requests[$];   // items waiting to be offered
	reply_t      lfu_replies_due[$];    // predicted results, oldest first
	int          fail_count = 0;
	logic        quiet = 1'b0;          // no random gaps or stalls while set
	logic        hold_armed = 1'b0;     // lets the long receiver hold-off start
	logic        long_hold = 1'b0;      // receiver refuses results while set
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	// shadow copy of the cache contents
	logic        tbl_valid[SLOTS];
	logic [31:0] tbl_key[SLOTS];
	logic [31:0] tbl_data[SLOTS];
	logic [15:0] tbl_count[SLOTS];
	logic [31:0] tbl_stamp[SLOTS];
	logic [31:0] touch_clk = '0;
	int          fill_level = 0;
	logic [4:0]  cap_setting = CAP_RESET;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_data[i]  = '0;
			tbl_count[i] = '0;
			tbl_stamp[i] = '0;
		end
	end

	// applies one access to the shadow cache and returns the result it gives
	function automatic reply_t lfu_apply(logic cmd, logic [31:0] k, logic [31:0] v);
		reply_t      r;
		int          eff_cap;
		int          slot;
		int          dst;
		logic [15:0] best_cnt;
		logic [31:0] best_age;
		logic [31:0] age;
		r.hit         = 1'b0;
		r.read_value  = MISS_VALUE;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		eff_cap = (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
		if (eff_cap == 0)
			return r;   // disabled: nothing read, nothing stored
		slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot < 0 && tbl_valid[i] && tbl_key[i] == k)
				slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			if (cmd == CMD_GET)
				r.read_value = tbl_data[slot];
			else
				tbl_data[slot] = v;
			if (tbl_count[slot] != COUNT_MAX)
				tbl_count[slot] = tbl_count[slot] + 16'd1;
			tbl_stamp[slot] = touch_clk;
			touch_clk = touch_clk + 32'd1;
		end else if (cmd == CMD_PUT) begin
			dst = -1;
			best_cnt = '0;
			best_age = '0;
			if (fill_level >= eff_cap) begin
				// lowest count loses, ties go to the oldest touch
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i]) begin
						age = touch_clk - tbl_stamp[i];
						if (dst < 0 || tbl_count[i] < best_cnt ||
								(tbl_count[i] == best_cnt && age > best_age)) begin
							dst = i;
							best_cnt = tbl_count[i];
							best_age = age;
						end
					end
				end
				if (dst >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = tbl_key[dst];
					tbl_valid[dst] = 1'b0;
					fill_level--;
				end
			end
			if (dst < 0)
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!tbl_valid[i])
						dst = i;
			if (dst >= 0) begin
				tbl_valid[dst] = 1'b1;
				tbl_key[dst]   = k;
				tbl_data[dst]  = v;
				tbl_count[dst] = COUNT_INIT;
				tbl_stamp[dst] = touch_clk;
				touch_clk = touch_clk + 32'd1;
				fill_level++;
			end
		end
		return r;
	endfunction

	// idle length before the next item or stall length on the result side:
	// mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request driver: offers queued items, holds a stalled item steady
	always @(posedge clk) begin
		request_t nxt;
		logic     slot_free;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			slot_free = !in_valid || !in_stall;
			// item taken at this edge: predict its result now
			if (in_valid && !in_stall)
				lfu_replies_due.push_back(lfu_apply(command, key, value));
			if (slot_free) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					nxt = pending_requests.pop_front();
					command  <= nxt.command;
					key      <= nxt.key;
					value    <= nxt.value;
					in_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each taken result against the oldest prediction
	always @(posedge clk) begin
		reply_t      want;
		logic        stall_now;
		int unsigned n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lfu_replies_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual hit=%0b",
						$time, hit, " read_value=%h evicted=%0b evicted_key=%h",
						read_value, evicted, evicted_key);
				end else begin
					want = lfu_replies_due.pop_front();
					if (hit !== want.hit) begin
						fail_count++;
						$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
					end
					if (read_value !== want.read_value) begin
						fail_count++;
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, read_value);
					end
					if (evicted !== want.evicted) begin
						fail_count++;
						$display("%0t: evicted expected %0b actual %0b",
							$time, want.evicted, evicted);
					end
					if (evicted_key !== want.evicted_key) begin
						fail_count++;
						$display("%0t: evicted_key expected %h actual %h",
							$time, want.evicted_key, evicted_key);
					end
				end
			end
			// random stall stretches on the result side
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				stall_now = 1'b1;
			end else begin
				n = pick_gap();
				stall_now = (n != 0);
				if (n != 0)
					stall_left <= n - 1;
			end
			out_stall <= long_hold | stall_now;
		end
	end

	// long receiver hold-off while the sender keeps offering items,
	// so the result register fills and the block stalls its input
	initial begin : receiver_hold_off
		wait (hold_armed);
		repeat (30) @(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// hard limit on the whole run
	initial begin : run_limit
		#20_000_000;
		$display("tb_lfu_cache_table_top NOT OK");
		$finish;
	end

	// pushes one item onto the pending queue
	task automatic queue_request(input logic cmd, input logic [31:0] k, input logic [31:0] v);
		request_t rq;
		rq.command = cmd;
		rq.key = k;
		rq.value = v;
		pending_requests.push_back(rq);
	endtask

	// sender pause: waits until every item is taken and every result is back
	task automatic drain_all();
		while (pending_requests.size() != 0 || in_valid || lfu_replies_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// capacity register write, only ever issued while the block is idle
	task automatic set_capacity(input logic [4:0] c);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_setting = c;
		@(negedge clk);
	endtask

	// stimulus sequence
	initial begin : stimulus
		logic [31:0] key_pool[24];
		logic [31:0] k;
		logic        cmd;
		logic [4:0]  phase_cap[8];
		int unsigned items;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 24; i++)
			key_pool[i] = $urandom;
		phase_cap = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd12, 5'd31, 5'd2, 5'd16};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, hits, misses, update of a present key
		set_capacity(5'd16);
		queue_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_request(CMD_GET, 32'h7FFF_FFFF, '0);
		queue_request(CMD_GET, 32'h0000_0000, '0);
		queue_request(CMD_GET, 32'hFFFF_FFFF, '0);
		queue_request(CMD_GET, 32'h0000_3039, '0);
		queue_request(CMD_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		queue_request(CMD_GET, 32'h7FFF_FFFF, '0);
		drain_all();

		// capacity dropped below the number of entries held
		set_capacity(5'd3);
		queue_request(CMD_PUT, 32'h0000_1111, 32'h0000_0001);
		queue_request(CMD_PUT, 32'h0000_2222, 32'h0000_0002);
		queue_request(CMD_GET, 32'h0000_1111, '0);
		drain_all();

		// capacity zero: every get misses, puts change nothing
		set_capacity(5'd0);
		queue_request(CMD_GET, 32'h0000_1111, '0);
		queue_request(CMD_PUT, 32'h0000_3333, 32'h0000_0003);
		queue_request(CMD_GET, 32'h0000_3333, '0);
		drain_all();

		// capacity above the table size, stored entries back in view
		set_capacity(5'd31);
		queue_request(CMD_GET, 32'h0000_1111, '0);
		queue_request(CMD_PUT, 32'h0000_4444, 32'h0000_0004);
		queue_request(CMD_GET, 32'h0000_4444, '0);
		drain_all();

		// random phases across several capacities; skewed key choice builds
		// up uneven counts, put-then-get pairs give hits with random content
		for (int ph = 0; ph < 8; ph++) begin
			set_capacity(phase_cap[ph]);
			quiet = (ph == 5) || (ph != 0 && $urandom_range(0, 5) == 0);
			items = 0;
			while (items < 145) begin
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, $urandom_range(0, 23))];
				else
					k = $urandom;
				if ($urandom_range(0, 99) < 20) begin
					queue_request(CMD_PUT, k, $urandom);
					queue_request(CMD_GET, k, $urandom);
					items += 2;
				end else begin
					cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
					queue_request(cmd, k, $urandom);
					items++;
				end
			end
			if (ph == 0)
				hold_armed = 1'b1;
			drain_all();
		end

		// all results back and the block settled
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_lfu_cache_table_top OK");
		else
			$display("tb_lfu_cache_table_top NOT OK");
		$finish;
	end

endmodule
